>>> rtl/core/mmp_pkg.sv
// ----------------------------------------------------------------------------
// Modular matrix power package
// Shared widths, constants, types and small modular helper functions.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int DIM      = 3;
  localparam int EXP_BITS = 63;
  localparam int RES_W    = 30;
  localparam int IDX_W    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int Q_W      = RES_W + 1;
  localparam int R_W      = RES_W + 2;
  localparam int NPAIR    = (DIM + 1) / 2;
  localparam int DOT_LAT  = 7;

  localparam logic [RES_W-1:0] MODULUS = 30'd998244353;
  localparam logic [Q_W-1:0]   MU      = Q_W'((64'd1 << (2 * RES_W)) / 64'(MODULUS));

  typedef logic [RES_W-1:0]          residue_t;
  typedef residue_t [DIM-1:0]        vec_t;
  typedef vec_t [DIM-1:0]            mat_t;

  typedef struct packed {
    logic             valid;
    logic             sq;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } dot_req_t;

  typedef struct packed {
    logic start;
    logic take;
  } seq_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic busy;
  } seq_sts_t;

  function automatic residue_t mod_add(input residue_t a, input residue_t b);
    logic [RES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[RES_W-1:0];
  endfunction

  function automatic residue_t mod_red(input residue_t a);
    return (a >= MODULUS) ? residue_t'(a - MODULUS) : a;
  endfunction

  function automatic mat_t ident_mat();
    mat_t m;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        m[i][j] = (i == j) ? residue_t'(1) : residue_t'(0);
      end
    end
    return m;
  endfunction

  function automatic logic all_reduced(input mat_t m);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        if (m[i][j] >= MODULUS) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

>>> rtl/core/mmp_in_if.sv
// ----------------------------------------------------------------------------
// Modular matrix power input channel
// Valid/ready channel carrying one matrix and its exponent per word.
// ----------------------------------------------------------------------------
interface mmp_in_if import mmp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RES_W-1:0]    m11;
  logic [RES_W-1:0]    m12;
  logic [RES_W-1:0]    m13;
  logic [RES_W-1:0]    m21;
  logic [RES_W-1:0]    m22;
  logic [RES_W-1:0]    m23;
  logic [RES_W-1:0]    m31;
  logic [RES_W-1:0]    m32;
  logic [RES_W-1:0]    m33;
  logic [EXP_BITS-1:0] power;

  modport source (
    output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, power,
    input  ready
  );

  modport sink (
    input  valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, power,
    output ready
  );
endinterface

>>> rtl/core/mmp_out_if.sv
// ----------------------------------------------------------------------------
// Modular matrix power result channel
// Valid/ready channel carrying one result matrix per word.
// ----------------------------------------------------------------------------
interface mmp_out_if import mmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] r11;
  logic [RES_W-1:0] r12;
  logic [RES_W-1:0] r13;
  logic [RES_W-1:0] r21;
  logic [RES_W-1:0] r22;
  logic [RES_W-1:0] r23;
  logic [RES_W-1:0] r31;
  logic [RES_W-1:0] r32;
  logic [RES_W-1:0] r33;

  modport source (
    output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
    input  ready
  );

  modport sink (
    input  valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
    output ready
  );
endinterface

>>> rtl/core/mmp_modmul.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Four-stage pipelined product of two residues with Barrett reduction.
// ----------------------------------------------------------------------------
module mmp_modmul import mmp_pkg::*; (
  input  logic     clk,
  input  residue_t a,
  input  residue_t b,
  output residue_t r
);

  logic [2*RES_W-1:0] prod_r;
  logic [2*Q_W-1:0]   t_r;
  logic [R_W-1:0]     x2_r;
  logic [R_W-1:0]     x3_r;
  logic [R_W-1:0]     qp_r;
  residue_t           r_r;
  logic [Q_W-1:0]     q1;
  logic [Q_W-1:0]     q3;
  logic [R_W-1:0]     diff;
  logic [R_W-1:0]     fixed;

  assign q1 = prod_r[2*RES_W-1:RES_W-1];
  assign q3 = t_r[2*Q_W-1:RES_W+1];

  // The estimate leaves a remainder below three times the modulus.
  always_comb begin
    diff = x3_r - qp_r;
    if (diff >= (R_W'(MODULUS) << 1)) begin
      fixed = diff - (R_W'(MODULUS) << 1);
    end else if (diff >= R_W'(MODULUS)) begin
      fixed = diff - R_W'(MODULUS);
    end else begin
      fixed = diff;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*RES_W)'(a) * (2*RES_W)'(b);
    t_r    <= (2*Q_W)'(q1) * (2*Q_W)'(MU);
    x2_r   <= prod_r[R_W-1:0];
    qp_r   <= R_W'((Q_W+RES_W)'(q3) * (Q_W+RES_W)'(MODULUS));
    x3_r   <= x2_r;
    r_r    <= fixed[RES_W-1:0];
  end

  assign r = r_r;

endmodule

>>> rtl/core/mmp_dot.sv
// ----------------------------------------------------------------------------
// Modular dot product unit
// One row times one column: a lane of modular multipliers and an adder tree.
// ----------------------------------------------------------------------------
module mmp_dot import mmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dot_req_t req,
  input  vec_t     a_row,
  input  vec_t     b_col,
  output dot_req_t rsp,
  output residue_t rsp_data,
  output logic     busy
);

  logic [DOT_LAT-1:0] vld_r;
  dot_req_t           tag_r [DOT_LAT];
  vec_t               a_r;
  vec_t               b_r;
  vec_t               prod;
  residue_t           pair_r [NPAIR];
  residue_t           sum_r;
  residue_t           fold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DOT_LAT-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= req;
    for (int s = 1; s < DOT_LAT; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    a_r <= a_row;
    b_r <= b_col;
  end

  for (genvar k = 0; k < DIM; k++) begin : g_lane
    mmp_modmul u_mul (
      .clk (clk),
      .a   (a_r[k]),
      .b   (b_r[k]),
      .r   (prod[k])
    );
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NPAIR; p++) begin
      if (2 * p + 1 < DIM) begin
        pair_r[p] <= mod_add(prod[2*p], prod[2*p+1]);
      end else begin
        pair_r[p] <= prod[2*p];
      end
    end
  end

  always_comb begin
    fold = pair_r[0];
    for (int p = 1; p < NPAIR; p++) begin
      fold = mod_add(fold, pair_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= fold;
  end

  always_comb begin
    rsp       = tag_r[DOT_LAT-1];
    rsp.valid = vld_r[DOT_LAT-1];
  end

  assign rsp_data = sum_r;
  assign busy     = |vld_r;

endmodule

>>> rtl/core/mmp_seq.sv
// ----------------------------------------------------------------------------
// Square-and-multiply sequencer
// Holds the running result and power matrices and feeds the dot product unit.
// ----------------------------------------------------------------------------
module mmp_seq import mmp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  seq_cmd_t            cmd,
  input  mat_t                in_mat,
  input  logic [EXP_BITS-1:0] in_power,
  output seq_sts_t            sts,
  output mat_t                res_mat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BIT   = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  mat_t                base_r;
  mat_t                acc_r;
  mat_t                nbase_r;
  mat_t                nacc_r;
  logic [EXP_BITS-1:0] exp_r;
  logic                sq_r;
  logic [IDX_W-1:0]    row_r;
  logic [IDX_W-1:0]    col_r;
  logic                exp_more;
  logic                last_entry;
  logic                dot_busy;
  dot_req_t            req;
  dot_req_t            rsp;
  residue_t            rsp_data;
  vec_t                a_row;
  vec_t                b_col;

  assign exp_more   = (exp_r >> 1) != '0;
  assign last_entry = (row_r == LAST_IDX) && (col_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        state_nxt = (exp_r == '0) ? ST_DONE : ST_ISSUE;
      end
      ST_ISSUE: begin
        if (last_entry && (sq_r || !exp_more)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dot_busy) begin
          state_nxt = ST_BIT;
        end
      end
      ST_DONE: begin
        if (cmd.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd.start) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          base_r[i][j] <= mod_red(in_mat[i][j]);
        end
      end
      acc_r <= ident_mat();
      exp_r <= in_power;
    end
    if (state_r == ST_BIT) begin
      sq_r  <= !exp_r[0];
      row_r <= '0;
      col_r <= '0;
    end
    if (state_r == ST_ISSUE) begin
      if (col_r == LAST_IDX) begin
        col_r <= '0;
        if (row_r == LAST_IDX) begin
          row_r <= '0;
          sq_r  <= 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
    if (state_r == ST_DRAIN && !dot_busy) begin
      if (exp_r[0]) begin
        acc_r <= nacc_r;
      end
      if (exp_more) begin
        base_r <= nbase_r;
      end
      exp_r <= exp_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      if (rsp.sq) begin
        nbase_r[rsp.row][rsp.col] <= rsp_data;
      end else begin
        nacc_r[rsp.row][rsp.col] <= rsp_data;
      end
    end
  end

  // The right-hand operand is the current power in both products.
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      a_row[k] = sq_r ? base_r[row_r][k] : acc_r[row_r][k];
      b_col[k] = base_r[k][col_r];
    end
  end

  always_comb begin
    req.valid = (state_r == ST_ISSUE);
    req.sq    = sq_r;
    req.row   = row_r;
    req.col   = col_r;
  end

  mmp_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .a_row    (a_row),
    .b_col    (b_col),
    .rsp      (rsp),
    .rsp_data (rsp_data),
    .busy     (dot_busy)
  );

  assign sts.idle = (state_r == ST_IDLE);
  assign sts.done = (state_r == ST_DONE);
  assign sts.busy = dot_busy;
  assign res_mat  = acc_r;

endmodule

>>> rtl/core/modular_matrix_power_3x3.sv
// ----------------------------------------------------------------------------
// Modular matrix power, 3x3
// Raises a 3x3 matrix to a 63-bit power modulo 998244353 by square-and-multiply.
//
//   channel  direction  word
//   in_ch    sink       m11..m33 (30 bits each), power (63 bits)
//   out_ch   source     r11..r33 (30 bits each)
//
// Each exponent bit up to the highest set bit passes through a decision state and then one
// or both matrix products through the shared dot product unit, followed by a pipeline drain.
// Reset is synchronous and active low; it clears the sequencer and valid flags.
// A new word is accepted while a finished result still waits in the output register;
// a stalled output holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module modular_matrix_power_3x3 import mmp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  mmp_in_if.sink   in_ch,
  mmp_out_if.source out_ch
);

  seq_cmd_t cmd;
  seq_sts_t sts;
  mat_t     in_mat;
  mat_t     res_mat;
  mat_t     out_mat_r;
  logic     out_valid_r;
  logic     out_load;

  assign in_mat[0][0] = in_ch.m11;
  assign in_mat[0][1] = in_ch.m12;
  assign in_mat[0][2] = in_ch.m13;
  assign in_mat[1][0] = in_ch.m21;
  assign in_mat[1][1] = in_ch.m22;
  assign in_mat[1][2] = in_ch.m23;
  assign in_mat[2][0] = in_ch.m31;
  assign in_mat[2][1] = in_ch.m32;
  assign in_mat[2][2] = in_ch.m33;

  assign in_ch.ready = sts.idle;
  assign out_load    = sts.done && (!out_valid_r || out_ch.ready);
  assign cmd.start   = in_ch.valid && in_ch.ready;
  assign cmd.take    = out_load;

  mmp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_mat   (in_mat),
    .in_power (in_ch.power),
    .sts      (sts),
    .res_mat  (res_mat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mat_r <= res_mat;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.r11   = out_mat_r[0][0];
  assign out_ch.r12   = out_mat_r[0][1];
  assign out_ch.r13   = out_mat_r[0][2];
  assign out_ch.r21   = out_mat_r[1][0];
  assign out_ch.r22   = out_mat_r[1][1];
  assign out_ch.r23   = out_mat_r[1][2];
  assign out_ch.r31   = out_mat_r[2][0];
  assign out_ch.r32   = out_mat_r[2][1];
  assign out_ch.r33   = out_mat_r[2][2];

  // No product may still be in flight while the sequencer waits for a word.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    sts.idle |-> !sts.busy)
    else $error("dot product unit busy while sequencer idle");

  a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (sts.idle && out_valid_r))
    else $error("sequencer did not return to idle after handing off a result");

  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> all_reduced(out_mat_r))
    else $error("result entry not below the modulus");

  a_no_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !cmd.start)
    else $error("word accepted while a result is pending in the sequencer");

endmodule
